// ===== hw/rtl/orbit_eccentricity_from_state_macros.svh =====
// Assertion macros shared by the orbit eccentricity RTL.
`ifndef ORBIT_ECCENTRICITY_FROM_STATE_MACROS_SVH
`define ORBIT_ECCENTRICITY_FROM_STATE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define ORB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define ORB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ORB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ORB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/orb_pkg.sv =====
// Types, constants and datapath step functions for the orbit eccentricity block.
package orb_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_GRAV_PARAM = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y   = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Z   = CFG_INDEX_W'(3);
    localparam logic [47:0] GRAV_PARAM_RESET = 48'd26122678534;

    localparam int QUEUE_DEPTH_DEF = 4;

    // Back pipeline stage map.
    localparam int ST_SQ       = 0;
    localparam int ST_DSQ      = 1;
    localparam int ST_PP       = 2;
    localparam int ST_TERM     = 3;
    localparam int ST_W        = 4;
    localparam int ST_PREP     = 5;
    localparam int ST_DIV0     = 6;
    localparam int DIV_STEPS   = 49;
    localparam int Q_STEPS     = 33;
    localparam int ST_USQ0     = ST_DIV0 + DIV_STEPS;
    localparam int USQ_STEPS   = 25;
    localparam int ST_E        = ST_USQ0 + USQ_STEPS;
    localparam int ST_ESQ      = ST_E + 1;
    localparam int ST_SUM      = ST_ESQ + 1;
    localparam int ST_FSQ0     = ST_SUM + 1;
    localparam int FSQ_STEPS   = 32;
    localparam int BK_STAGES   = ST_FSQ0 + FSQ_STEPS;

    // One entry of the front-to-back queue.
    typedef struct {
        logic               zero;
        logic signed [32:0] d [3];
        logic signed [31:0] v [3];
    } q_entry_t;

    // Everything one item carries through the back pipeline.
    typedef struct {
        logic               zero;
        logic               sat;
        logic signed [32:0] d [3];
        logic signed [31:0] v [3];
        logic [63:0]        sq [3];
        logic [65:0]        dsq;
        logic signed [64:0] p [6];
        logic signed [65:0] h [3];
        logic signed [65:0] pl [6];
        logic signed [64:0] ph [6];
        logic signed [99:0] t [6];
        logic signed [99:0] w [3];
        logic               wneg [3];
        logic [55:0]        qr [3];
        logic [32:0]        wlo [3];
        logic [32:0]        q [3];
        logic [65:0]        ur [3];
        logic               ubit [3];
        logic [48:0]        uq [3];
        logic               dneg [3];
        logic [64:0]        ux [3];
        logic [64:0]        ures [3];
        logic [31:0]        ea [3];
        logic [63:0]        es [3];
        logic [64:0]        fx;
        logic [64:0]        fres;
    } bk_t;

    typedef struct packed {
        logic [64:0] x;
        logic [64:0] res;
    } sq_t;

    // One digit of the bitwise integer square root.
    function automatic sq_t isqrt_step(input logic [64:0] x, input logic [64:0] res,
                                       input logic [64:0] bv);
        sq_t         o;
        logic [64:0] tr;
        tr = res + bv;
        if (x >= tr)
        begin
            o.x   = x - tr;
            o.res = (res >> 1) + bv;
        end
        else
        begin
            o.x   = x;
            o.res = res >> 1;
        end
        return o;
    endfunction

    // Low partial product: v times the low 33 bits of h taken as unsigned.
    function automatic logic signed [65:0] mul_lo(input logic signed [31:0] v,
                                                  input logic signed [65:0] h);
        return 66'(v) * 66'($signed({1'b0, h[32:0]}));
    endfunction

    // High partial product: v times the upper 33 bits of h.
    function automatic logic signed [64:0] mul_hi(input logic signed [31:0] v,
                                                  input logic signed [65:0] h);
        return 65'(v) * 65'($signed(h[65:33]));
    endfunction

    function automatic bk_t bk_init(input q_entry_t e);
        bk_t n;
        n = '{default: '0};
        n.zero = e.zero;
        for (int i = 0; i < 3; i++)
        begin
            n.d[i] = e.d[i];
            n.v[i] = e.v[i];
        end
        return n;
    endfunction

    // Work done by back stage j on the item it holds.
    function automatic bk_t bk_step(input int j, input bk_t s, input logic [55:0] den);
        bk_t                n;
        int                 k;
        logic signed [65:0] sp;
        logic signed [99:0] wa;
        logic [66:0]        ut;
        logic [56:0]        qt;
        logic signed [34:0] qs;
        logic signed [34:0] us;
        logic signed [34:0] ev;
        logic [34:0]        eab;
        logic [65:0]        sum;
        logic [64:0]        bv;
        sq_t                r;
        n = s;
        if (j == ST_SQ)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sp = 66'(s.d[i]) * 66'(s.d[i]);
                n.sq[i] = sp[63:0];
            end
            n.p[0] = 65'(s.d[1]) * 65'(s.v[2]);
            n.p[1] = 65'(s.d[2]) * 65'(s.v[1]);
            n.p[2] = 65'(s.d[2]) * 65'(s.v[0]);
            n.p[3] = 65'(s.d[0]) * 65'(s.v[2]);
            n.p[4] = 65'(s.d[0]) * 65'(s.v[1]);
            n.p[5] = 65'(s.d[1]) * 65'(s.v[0]);
        end
        else if (j == ST_DSQ)
        begin
            n.dsq  = 66'(s.sq[0]) + 66'(s.sq[1]) + 66'(s.sq[2]);
            n.h[0] = 66'(s.p[0]) - 66'(s.p[1]);
            n.h[1] = 66'(s.p[2]) - 66'(s.p[3]);
            n.h[2] = 66'(s.p[4]) - 66'(s.p[5]);
        end
        else if (j == ST_PP)
        begin
            // w0 = v1*h2 - v2*h1, w1 = v2*h0 - v0*h2, w2 = v0*h1 - v1*h0
            n.pl[0] = mul_lo(s.v[1], s.h[2]);
            n.ph[0] = mul_hi(s.v[1], s.h[2]);
            n.pl[1] = mul_lo(s.v[2], s.h[1]);
            n.ph[1] = mul_hi(s.v[2], s.h[1]);
            n.pl[2] = mul_lo(s.v[2], s.h[0]);
            n.ph[2] = mul_hi(s.v[2], s.h[0]);
            n.pl[3] = mul_lo(s.v[0], s.h[2]);
            n.ph[3] = mul_hi(s.v[0], s.h[2]);
            n.pl[4] = mul_lo(s.v[0], s.h[1]);
            n.ph[4] = mul_hi(s.v[0], s.h[1]);
            n.pl[5] = mul_lo(s.v[1], s.h[0]);
            n.ph[5] = mul_hi(s.v[1], s.h[0]);
        end
        else if (j == ST_TERM)
        begin
            for (int i = 0; i < 6; i++)
            begin
                n.t[i] = (100'(s.ph[i]) <<< 33) + 100'(s.pl[i]);
            end
        end
        else if (j == ST_W)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n.w[i] = s.t[2*i] - s.t[2*i+1];
            end
        end
        else if (j == ST_PREP)
        begin
            for (int i = 0; i < 3; i++)
            begin
                wa = s.w[i][99] ? -s.w[i] : s.w[i];
                n.wneg[i] = s.w[i][99];
                if ($unsigned(wa) >= {11'b0, den, 33'b0})
                begin
                    n.sat = 1'b1;
                end
                n.qr[i]   = wa[88:33];
                n.wlo[i]  = wa[32:0];
                n.q[i]    = '0;
                n.ur[i]   = {3'b0, s.sq[i][63:1]};
                n.ubit[i] = s.sq[i][0];
                n.uq[i]   = '0;
                n.dneg[i] = s.d[i][32];
            end
        end
        else if (j >= ST_DIV0 && j < ST_USQ0)
        begin
            k = j - ST_DIV0;
            for (int i = 0; i < 3; i++)
            begin
                // Unit vector component: d_i^2 * 2^48 / |d|^2, one quotient bit.
                ut = {s.ur[i], (k == 0) ? s.ubit[i] : 1'b0};
                if (ut >= {1'b0, s.dsq})
                begin
                    n.ur[i] = 66'(ut - {1'b0, s.dsq});
                    n.uq[i] = {s.uq[i][47:0], 1'b1};
                end
                else
                begin
                    n.ur[i] = ut[65:0];
                    n.uq[i] = {s.uq[i][47:0], 1'b0};
                end
                // w_i / (mu * 2^8), one quotient bit.
                if (k < Q_STEPS)
                begin
                    qt = {s.qr[i], s.wlo[i][32]};
                    n.wlo[i] = {s.wlo[i][31:0], 1'b0};
                    if (qt >= {1'b0, den})
                    begin
                        n.qr[i] = 56'(qt - {1'b0, den});
                        n.q[i]  = {s.q[i][31:0], 1'b1};
                    end
                    else
                    begin
                        n.qr[i] = qt[55:0];
                        n.q[i]  = {s.q[i][31:0], 1'b0};
                    end
                end
            end
        end
        else if (j >= ST_USQ0 && j < ST_E)
        begin
            k = j - ST_USQ0;
            bv = 65'(1) << (2 * (USQ_STEPS - 1 - k));
            for (int i = 0; i < 3; i++)
            begin
                if (k == 0)
                begin
                    r = isqrt_step({16'b0, s.uq[i]}, 65'd0, bv);
                end
                else
                begin
                    r = isqrt_step(s.ux[i], s.ures[i], bv);
                end
                n.ux[i]   = r.x;
                n.ures[i] = r.res;
            end
        end
        else if (j == ST_E)
        begin
            for (int i = 0; i < 3; i++)
            begin
                qs = $signed({2'b0, s.q[i]});
                if (s.wneg[i])
                begin
                    qs = -qs;
                end
                us = $signed({10'b0, s.ures[i][24:0]});
                if (s.dneg[i])
                begin
                    us = -us;
                end
                ev  = qs - us;
                eab = ev[34] ? $unsigned(-ev) : $unsigned(ev);
                if (eab[34:32] != 3'b0)
                begin
                    n.sat = 1'b1;
                end
                n.ea[i] = eab[31:0];
            end
        end
        else if (j == ST_ESQ)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n.es[i] = {32'b0, s.ea[i]} * {32'b0, s.ea[i]};
            end
        end
        else if (j == ST_SUM)
        begin
            sum = {2'b0, s.es[0]} + {2'b0, s.es[1]} + {2'b0, s.es[2]};
            if (sum[65:64] != 2'b0)
            begin
                n.sat = 1'b1;
            end
            n.fx   = {1'b0, sum[63:0]};
            n.fres = '0;
        end
        else if (j >= ST_FSQ0 && j < BK_STAGES)
        begin
            k  = j - ST_FSQ0;
            bv = 65'(1) << (2 * (FSQ_STEPS - 1 - k));
            r  = isqrt_step(s.fx, s.fres, bv);
            n.fx   = r.x;
            n.fres = r.res;
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/orbit_eccentricity_from_state.sv =====
// Top level of the orbit eccentricity block: configuration registers, front, queue and back.
//
// Each input beat carries one Cartesian state (position in signed Q23.8 km, velocity in
// signed Q11.20 km/s); each output beat carries the magnitude of the eccentricity vector
// e = v x (r x v) / mu - r / |r| as unsigned Q8.24, where r is the position relative to
// the configured central body. The result saturates at all ones when it does not fit, and
// when r is the zero vector the tuser flag is set and the eccentricity reads zero. A mu of
// zero behaves as one. The block takes one beat per clock cycle when the output side is
// ready; each accepted beat passes the front register, the queue and the 115 back
// stages, the last of which is the output register. The back pipeline's depth is set by
// the 49-step long division that forms each component of r/|r|, the 25-step square root
// after it and the 32-step square root of the final norm. A short queue between the front
// and back parts lets the input side keep streaming for a few beats while the output side
// stalls. The user must write configuration only while no item is in flight; the block
// itself does not enforce this. Unknown register indexes are ignored.
module orbit_eccentricity_from_state
    import orb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [47:0]            cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata, lowest bits first: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (32 bits each).
    input  logic [191:0]           s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: eccentricity (32 bits).
    output logic [31:0]            m_axis_tdata,
    // tuser: zero_radius (1 bit).
    output logic                   m_axis_tuser
);

    logic [47:0]        grav_param_reg;
    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic signed [31:0] center_z_reg;
    logic [47:0]        mu_eff;
    logic [55:0]        den;
    logic               push;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    q_entry_t           ent;
    q_entry_t           q_data;

    // Registers are always writable; the divisor is mu scaled to line up with w in Q.48.
    assign cfg_ready = 1'b1;
    assign mu_eff    = (grav_param_reg == '0) ? 48'd1 : grav_param_reg;
    assign den       = {mu_eff, 8'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_param_reg <= GRAV_PARAM_RESET;
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            center_z_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GRAV_PARAM: grav_param_reg <= cfg_data;
                REG_CENTER_X:   center_x_reg   <= $signed(cfg_data[31:0]);
                REG_CENTER_Y:   center_y_reg   <= $signed(cfg_data[31:0]);
                REG_CENTER_Z:   center_z_reg   <= $signed(cfg_data[31:0]);
                default: ;
            endcase
        end
    end

    // The front stage subtracts the center and marks a zero radius before queueing.
    orb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .center_x (center_x_reg),
        .center_y (center_y_reg),
        .center_z (center_z_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .pos_x    ($signed(s_axis_tdata[31:0])),
        .pos_y    ($signed(s_axis_tdata[63:32])),
        .pos_z    ($signed(s_axis_tdata[95:64])),
        .vel_x    ($signed(s_axis_tdata[127:96])),
        .vel_y    ($signed(s_axis_tdata[159:128])),
        .vel_z    ($signed(s_axis_tdata[191:160])),
        .q_full   (q_full),
        .push     (push),
        .ent      (ent)
    );

    orb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (ent),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_data),
        .valid (q_valid)
    );

    // The back pipeline holds its last stage as the output register.
    orb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .den           (den),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== hw/rtl/orb_front.sv =====
// Front stage: takes input beats, forms the relative position and flags a zero radius.
module orb_front
    import orb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic               q_full,
    output logic               push,
    output q_entry_t           ent
);

    q_entry_t ent_reg;
    q_entry_t ent_next;
    logic     fvld_reg;
    logic     fvld_next;
    logic     take;

    assign push     = fvld_reg && !q_full;
    assign in_ready = !fvld_reg || !q_full;
    assign take     = in_valid && in_ready;
    assign ent      = ent_reg;

    always_comb
    begin
        ent_next.d[0] = 33'(pos_x) - 33'(center_x);
        ent_next.d[1] = 33'(pos_y) - 33'(center_y);
        ent_next.d[2] = 33'(pos_z) - 33'(center_z);
        ent_next.v[0] = vel_x;
        ent_next.v[1] = vel_y;
        ent_next.v[2] = vel_z;
        ent_next.zero = (ent_next.d[0] == '0) && (ent_next.d[1] == '0)
                        && (ent_next.d[2] == '0);
        fvld_next     = take || (fvld_reg && !push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fvld_reg <= 1'b0;
        end
        else
        begin
            fvld_reg <= fvld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ent_reg <= ent_next;
        end
    end

endmodule

// ===== hw/rtl/orb_queue.sv =====
// Short first-word-fall-through queue between the front stage and the back pipeline.
`include "orbit_eccentricity_from_state_macros.svh"
module orb_queue
    import orb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t din,
    output logic     full,
    input  logic     pop,
    output q_entry_t dout,
    output logic     valid
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    q_entry_t        mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   cnt_reg;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign valid = (cnt_reg != '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    `ORB_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full, "push into a full queue")
    `ORB_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, valid, "pop from an empty queue")
    `ORB_ASSERT_NXT(a_count_up, clk, rst_n, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1, "queue count did not grow on push")

endmodule

// ===== hw/rtl/orb_back.sv =====
// Back pipeline: cross products, long divisions, square roots and the eccentricity norm.
`include "orbit_eccentricity_from_state_macros.svh"
module orb_back
    import orb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [55:0] den,
    input  logic        q_valid,
    input  q_entry_t    q_data,
    output logic        q_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tuser
);

    logic en;
    logic vld_reg [BK_STAGES];
    bk_t  st_reg  [BK_STAGES];
    bk_t  last;

    // The whole pipeline moves together whenever the output slot is free.
    assign en    = !vld_reg[BK_STAGES-1] || m_axis_tready;
    assign q_pop = en && q_valid;

    for (genvar j = 0; j < BK_STAGES; j++)
    begin : g_stage
        bk_t  src;
        logic src_vld;
        if (j == 0)
        begin : g_head
            assign src     = bk_init(q_data);
            assign src_vld = q_valid;
        end
        else
        begin : g_body
            assign src     = st_reg[j-1];
            assign src_vld = vld_reg[j-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[j] <= bk_step(j, src, den);
            end
        end
    end

    assign last          = st_reg[BK_STAGES-1];
    assign m_axis_tvalid = vld_reg[BK_STAGES-1];
    assign m_axis_tuser  = last.zero;
    assign m_axis_tdata  = last.zero ? 32'd0 : (last.sat ? 32'hFFFF_FFFF : last.fres[31:0]);

    `ORB_ASSERT_NXT(a_pop_loads_head, clk, rst_n, q_pop, vld_reg[0], "popped item missing from first stage")
    `ORB_ASSERT_NXT(a_stall_keeps_head, clk, rst_n, vld_reg[0] && !en, vld_reg[0], "item lost during stall")

endmodule

// ===== tb/orbit_ecc_checker.sv =====
// Checker for the orbit eccentricity block: watches all channels, predicts and compares.
`timescale 1ns / 100ps

module orbit_ecc_checker
    import orb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [47:0]            cfg_data,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [191:0]           s_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [31:0]            m_axis_tdata,
    input  logic                   m_axis_tuser,
    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        logic        zero_radius;
        logic [31:0] ecc;
    } ecc_result_t;

    logic [47:0]        mu_reg;
    logic signed [31:0] center_reg [3];
    ecc_result_t        ecc_expected [$];

    assign pending = ecc_expected.size();

    function automatic logic [127:0] int_sqrt(input logic [127:0] x);
        logic [127:0] root;
        logic [127:0] trial;
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            trial = root | (128'd1 << b);
            if (trial * trial <= x)
            begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Eccentricity of one state, computed with exact wide integers.
    function automatic ecc_result_t eccentricity_of(input logic [191:0] beat);
        logic signed [127:0] d [3];
        logic signed [127:0] v [3];
        logic signed [127:0] h [3];
        logic signed [127:0] w [3];
        logic signed [127:0] dsq;
        logic signed [127:0] den;
        logic signed [127:0] wmag;
        logic signed [127:0] q;
        logic signed [127:0] u;
        logic signed [127:0] e;
        logic signed [127:0] sum;
        logic [127:0]        norm;
        logic                sat;
        ecc_result_t         res;
        dsq = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = 128'($signed(beat[32*i +: 32])) - 128'(center_reg[i]);
            v[i] = 128'($signed(beat[32*(i+3) +: 32]));
            dsq  = dsq + d[i] * d[i];
        end
        res.zero_radius = (dsq == 0);
        res.ecc = '0;
        if (dsq == 0)
        begin
            return res;
        end
        h[0] = d[1] * v[2] - d[2] * v[1];
        h[1] = d[2] * v[0] - d[0] * v[2];
        h[2] = d[0] * v[1] - d[1] * v[0];
        w[0] = v[1] * h[2] - v[2] * h[1];
        w[1] = v[2] * h[0] - v[0] * h[2];
        w[2] = v[0] * h[1] - v[1] * h[0];
        // A mu of zero divides as if it were one.
        den = 128'((mu_reg == 0) ? 48'd1 : mu_reg) <<< 8;
        sat = 1'b0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            wmag = (w[i] < 0) ? -w[i] : w[i];
            q    = wmag / den;
            if (q >= (128'sd1 <<< 33))
            begin
                sat = 1'b1;
            end
            if (w[i] < 0)
            begin
                q = -q;
            end
            u = 0;
            if (d[i] != 0)
            begin
                u = $signed(int_sqrt(((d[i] * d[i]) <<< 48) / dsq));
                if (d[i] < 0)
                begin
                    u = -u;
                end
            end
            e = q - u;
            if (e >= (128'sd1 <<< 32) || -e >= (128'sd1 <<< 32))
            begin
                sat = 1'b1;
            end
            sum = sum + e * e;
        end
        if (sum >= (128'sd1 <<< 64))
        begin
            sat = 1'b1;
        end
        norm    = int_sqrt(sum);
        res.ecc = sat ? 32'hFFFF_FFFF : norm[31:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ecc_result_t got;
        ecc_result_t want;
        if (!rst_n)
        begin
            mu_reg     <= GRAV_PARAM_RESET;
            center_reg <= '{default: '0};
            fail_count <= 0;
            ecc_expected.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_GRAV_PARAM)
                begin
                    mu_reg <= cfg_data;
                end
                else if (cfg_index == REG_CENTER_X)
                begin
                    center_reg[0] <= cfg_data[31:0];
                end
                else if (cfg_index == REG_CENTER_Y)
                begin
                    center_reg[1] <= cfg_data[31:0];
                end
                else if (cfg_index == REG_CENTER_Z)
                begin
                    center_reg[2] <= cfg_data[31:0];
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                ecc_expected.insert(ecc_expected.size(), eccentricity_of(s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.ecc         = m_axis_tdata;
                got.zero_radius = m_axis_tuser;
                if (ecc_expected.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("%0t: unexpected result beat ecc=%h zero=%b",
                                 $realtime, got.ecc, got.zero_radius);
                    end
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = ecc_expected.pop_front();
                    if (got != want)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: mismatch ecc exp=%h got=%h zero exp=%b got=%b",
                                     $realtime, want.ecc, got.ecc,
                                     want.zero_radius, got.zero_radius);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
// Top of the orbit eccentricity testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb
    import orb_pkg::*;
();

    // An index that maps to no register; writes to it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = CFG_INDEX_W'(7);
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 160;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [47:0]            cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [191:0]           s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [31:0]            m_axis_tdata;
    logic                   m_axis_tuser;
    int                     fail_count;
    int                     pending;
    int                     cycle_count = 0;

    // The testbench's own view of the central body, used to aim states at it.
    logic signed [31:0]     body_pos [3];
    // When set, neither side inserts gaps.
    logic                   steady;

    orbit_eccentricity_from_state dut (.*);

    orbit_ecc_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // The run is bounded by a plain cycle counter.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** orbit_eccentricity_from_state: FAILED **");
            $finish;
        end
    end

    // Mostly no gap, sometimes a short one, now and then a long one, none at all in steady stretches.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 70)
        begin
            return 0;
        end
        else if (roll < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    // Output side: random stalls so that back pressure hits every pipeline phase.
    initial
    begin
        int g;
        m_axis_tready = 1'b0;
        @(posedge clk);
        forever
        begin
            g = pick_gap();
            if (g > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_CENTER_X)
        begin
            body_pos[0] = val[31:0];
        end
        else if (idx == REG_CENTER_Y)
        begin
            body_pos[1] = val[31:0];
        end
        else if (idx == REG_CENTER_Z)
        begin
            body_pos[2] = val[31:0];
        end
        @(posedge clk);
    endtask

    // Every result in, then a pipeline's worth of quiet before touching registers.
    task automatic wait_drained();
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_state(input logic [191:0] beat);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
    endtask

    function automatic logic [191:0] pack_state(input logic [31:0] px, input logic [31:0] py,
                                                input logic [31:0] pz, input logic [31:0] vx,
                                                input logic [31:0] vy, input logic [31:0] vz);
        return {vz, vy, vx, pz, py, px};
    endfunction

    // Random state: mostly bound-orbit sized vectors around the body, then raw noise,
    // states sitting on the body, and tiny offsets.
    function automatic logic [191:0] random_state();
        int          kind;
        logic [31:0] f [6];
        kind = $urandom_range(0, 99);
        for (int i = 0; i < 3; i++)
        begin
            if (kind < 60)
            begin
                f[i]   = body_pos[i] + $signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000;
                f[i+3] = $signed($urandom_range(0, 32'hFF_FFFF)) - 32'sh80_0000;
            end
            else if (kind < 80)
            begin
                f[i]   = $urandom;
                f[i+3] = $urandom;
            end
            else if (kind < 88)
            begin
                f[i]   = body_pos[i];
                f[i+3] = $urandom;
            end
            else
            begin
                f[i]   = body_pos[i] + $signed($urandom_range(0, 6)) - 3;
                f[i+3] = $signed($urandom_range(0, 64)) - 32;
            end
        end
        return pack_state(f[0], f[1], f[2], f[3], f[4], f[5]);
    endfunction

    task automatic random_phase(input int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
            begin
                steady = ($urandom_range(0, 3) == 0);
            end
            send_state(random_state());
        end
        s_axis_tvalid <= 1'b0;
        steady = 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] mx;
        logic [31:0] mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        steady        = 1'b0;
        body_pos      = '{default: '0};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed states under the reset configuration.
        send_state('0);
        send_state(pack_state(0, 0, 0, mx, mn, 32'h1234_5678));
        // Circular low orbit: 7000 km on x, about 7.546 km/s along y.
        send_state(pack_state(32'd1792000, 0, 0, 0, 32'd7912557, 0));
        send_state(pack_state(32'd1792000, 0, 0, 0, 32'd9000000, 0));
        send_state(pack_state(0, 32'hFFE4_A800, 0, 0, 0, 32'd7912557));
        send_state(pack_state(mx, mx, mx, mx, mx, mx));
        send_state(pack_state(mn, mn, mn, mn, mn, mn));
        send_state(pack_state(mx, mn, mx, mn, mx, mn));
        send_state(pack_state(1, 0, 0, 0, 0, 0));
        send_state(pack_state(32'hFFFF_FFFF, 1, 0, 0, 0, 0));
        send_state(pack_state(1, 1, 1, 1, 1, 1));
        send_state(pack_state(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0));
        s_axis_tvalid <= 1'b0;
        @(posedge clk);

        // Sender holds off until every outstanding result has arrived.
        wait_drained();
        random_phase(280);
        wait_drained();

        // Body at the positive extremes, smallest mu; then a state on the body and one at the far extreme.
        write_reg(REG_GRAV_PARAM, 48'd1);
        write_reg(REG_CENTER_X, {16'hFFFF, mx});
        write_reg(REG_CENTER_Y, {16'h0000, mx});
        write_reg(REG_CENTER_Z, {16'h0000, mx});
        write_reg(REG_UNMAPPED, 48'hFFFF_FFFF_FFFF);
        send_state(pack_state(mx, mx, mx, mx, mx, mx));
        send_state(pack_state(mn, mn, mn, mn, mn, mn));
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        random_phase(280);
        wait_drained();

        // Zero mu divides as one; body at the negative extremes.
        write_reg(REG_GRAV_PARAM, 48'd0);
        write_reg(REG_CENTER_X, {16'h0000, mn});
        write_reg(REG_CENTER_Y, {16'hFFFF, mn});
        write_reg(REG_CENTER_Z, {16'h0000, mn});
        send_state(pack_state(mx, mx, mx, 1, 1, 1));
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        random_phase(280);
        wait_drained();

        // Largest mu with the body back at the origin.
        write_reg(REG_GRAV_PARAM, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_CENTER_X, 48'd0);
        write_reg(REG_CENTER_Y, 48'd0);
        write_reg(REG_CENTER_Z, 48'd0);
        random_phase(280);
        wait_drained();

        // Earth mu again with a random body position.
        write_reg(REG_GRAV_PARAM, GRAV_PARAM_RESET);
        write_reg(REG_CENTER_X, {16'h0, 32'($urandom)});
        write_reg(REG_CENTER_Y, {16'h0, 32'($urandom)});
        write_reg(REG_CENTER_Z, {16'h0, 32'($urandom)});
        random_phase(300);
        wait_drained();

        // Random mu and body to finish.
        write_reg(REG_GRAV_PARAM, {16'($urandom), 32'($urandom)});
        write_reg(REG_CENTER_X, {16'h0, 32'($urandom_range(0, 32'h00FF_FFFF))});
        write_reg(REG_CENTER_Y, {16'h0, 32'($urandom)});
        write_reg(REG_CENTER_Z, {16'h0, 32'($urandom)});
        random_phase(300);
        wait_drained();

        if (fail_count == 0)
        begin
            $display("** orbit_eccentricity_from_state: PASSED **");
        end
        else
        begin
            $display("** orbit_eccentricity_from_state: FAILED **");
        end
        $finish;
    end

endmodule
